FILE: rtl/core/csl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csl_pkg
// shared constants and types of the c source lexer
// ----------------------------------------------------------------------------
package csl_pkg;

  // default longest token, in characters
  localparam int MAX_TOKEN_LEN = 64;

  // token classes
  localparam logic [3:0] CLS_ID        = 4'd0;
  localparam logic [3:0] CLS_NUMBER    = 4'd1;
  localparam logic [3:0] CLS_COMMA     = 4'd2;
  localparam logic [3:0] CLS_COLON     = 4'd3;
  localparam logic [3:0] CLS_SEMICOLON = 4'd4;
  localparam logic [3:0] CLS_LBRACE    = 4'd5;
  localparam logic [3:0] CLS_RBRACE    = 4'd6;
  localparam logic [3:0] CLS_LPAREN    = 4'd7;
  localparam logic [3:0] CLS_RPAREN    = 4'd8;
  localparam logic [3:0] CLS_LBRACKET  = 4'd9;
  localparam logic [3:0] CLS_RBRACKET  = 4'd10;
  localparam logic [3:0] CLS_NEWLINE   = 4'd11;
  localparam logic [3:0] CLS_END       = 4'd12;
  localparam logic [3:0] CLS_UNKNOWN   = 4'd13;
  localparam logic [3:0] CLS_TOO_LONG  = 4'd14;

  // event kinds
  localparam logic EV_APPEND   = 1'b0;
  localparam logic EV_COMPLETE = 1'b1;

  // characters with a meaning of their own
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LH    = 8'h68;

  // one result item
  typedef struct packed {
    logic        event_res;
    logic [3:0]  token_class;
    logic [7:0]  char_value;
    logic [6:0]  token_length;
    logic [15:0] start_line;
    logic [15:0] start_col;
    logic        last;
  } csl_res_t;

endpackage
`default_nettype wire

FILE: rtl/core/c_source_lexer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c_source_lexer
// character level lexer for c-like source text, one source byte per item
// ----------------------------------------------------------------------------
// The lexer takes one source byte per cycle on the slave stream and returns
// append and token-complete items on the master stream, each with the line and
// column where its token began. A byte is classified and the lexer state is
// updated in the cycle it is accepted; its zero, one or two results go into a
// four-entry result queue that feeds the master port. The slave side is ready
// whenever the queue has room for two results, so a new byte is taken every
// cycle while the output keeps up; the master port delivers one result per
// cycle, so a byte that ends an identifier or number and also starts a new
// token yields two results to deliver. After reset the lexer is ready at once.
// ----------------------------------------------------------------------------
module c_source_lexer
  import csl_pkg::*;
#(
  parameter int MaxTokenLen = MAX_TOKEN_LEN  // 2 .. 127
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // source byte stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] ch
  input  wire  [0:0]  s_axis_tuser,   // [0] end_of_input
  // result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] char_value, [14:8] token_length,
                                      // [30:15] start_line, [46:31] start_col
  output logic [4:0]  m_axis_tuser,   // [0] event_res, [4:1] token_class
  output logic        m_axis_tlast    // last
);

  localparam int CntW = $clog2(MaxTokenLen + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxTokenLen);

  // lexer modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_ID   = 2'd1;
  localparam logic [1:0] MODE_NUM  = 2'd2;

  // result queue geometry
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // --------------------------------------------------------------------------
  // lexer state
  // --------------------------------------------------------------------------
  logic [1:0]      mode_q, mode_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     line_q, line_d;
  logic [15:0]     col_q, col_d;
  logic [15:0]     tok_line_q, tok_line_d;
  logic [15:0]     tok_col_q, tok_col_d;
  logic            olz_q, olz_d;   // number so far is a lone leading zero

  logic            accept;
  logic [7:0]      c;
  logic [7:0]      lc;

  // end of input is lexed as a nul byte
  assign c  = s_axis_tuser[0] ? CH_NUL : s_axis_tdata;
  assign lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;

  function automatic logic is_alpha(input logic [7:0] v);
    return (v >= "a" && v <= "z") || (v >= "A" && v <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] v);
    return v >= "0" && v <= "9";
  endfunction

  function automatic logic is_lxdigit(input logic [7:0] v);
    return is_digit(v) || (v >= "a" && v <= "f");
  endfunction

  function automatic csl_res_t mk_res(input logic ev, input logic [3:0] cls,
                                      input logic [7:0] chv, input logic [CntW-1:0] len,
                                      input logic [15:0] sl, input logic [15:0] sc);
    csl_res_t r;
    r.event_res    = ev;
    r.token_class  = cls;
    r.char_value   = chv;
    r.token_length = 7'(len);
    r.start_line   = sl;
    r.start_col    = sc;
    r.last         = 1'b0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // idle-mode classification, used for a byte seen in idle and for the byte
  // that terminates an identifier or number
  // --------------------------------------------------------------------------
  logic            idl_v;
  csl_res_t        idl_res;
  logic [1:0]      idl_mode;
  logic [CntW-1:0] idl_cnt;
  logic            idl_olz;
  logic [3:0]      idl_cls;

  always_comb begin
    idl_v    = 1'b1;
    idl_mode = MODE_IDLE;
    idl_cnt  = '0;
    idl_olz  = 1'b0;
    idl_cls  = CLS_UNKNOWN;
    case (c)
      ",":    idl_cls = CLS_COMMA;
      ":":    idl_cls = CLS_COLON;
      ";":    idl_cls = CLS_SEMICOLON;
      "{":    idl_cls = CLS_LBRACE;
      "}":    idl_cls = CLS_RBRACE;
      "(":    idl_cls = CLS_LPAREN;
      ")":    idl_cls = CLS_RPAREN;
      "[":    idl_cls = CLS_LBRACKET;
      "]":    idl_cls = CLS_RBRACKET;
      CH_LF:  idl_cls = CLS_NEWLINE;
      CH_NUL: idl_cls = CLS_END;
      default: idl_cls = CLS_UNKNOWN;
    endcase
    if (idl_cls == CLS_UNKNOWN) begin
      idl_res = mk_res(EV_COMPLETE, CLS_UNKNOWN, c, '0, line_d, col_d);
    end else begin
      idl_res = mk_res(EV_COMPLETE, idl_cls, 8'h00, '0, line_d, col_d);
    end
    if (is_alpha(c) || c == CH_UNDER || c == CH_HASH) begin
      // identifier opens, first char always fits
      idl_mode = MODE_ID;
      idl_cnt  = CntW'(1);
      idl_res  = mk_res(EV_APPEND, CLS_ID, c, CntW'(1), line_d, col_d);
    end else if (is_digit(c)) begin
      idl_mode = MODE_NUM;
      idl_cnt  = CntW'(1);
      idl_olz  = (c == "0");
      idl_res  = mk_res(EV_APPEND, CLS_NUMBER, c, CntW'(1), line_d, col_d);
    end else if (c == CH_SPACE || c == CH_TAB) begin
      idl_v = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // per-byte rule: an optional result of the current token, then possibly
  // the idle rule on the same byte
  // --------------------------------------------------------------------------
  logic            a_v;       // token result present
  csl_res_t        a_res;
  logic            run_idle;
  logic            full;      // token already holds the longest length
  logic [CntW-1:0] cnt_inc;

  assign full    = (cnt_q >= CntMax);
  assign cnt_inc = cnt_q + CntW'(1);

  always_comb begin
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    olz_d      = olz_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    a_v        = 1'b0;
    a_res      = mk_res(EV_APPEND, CLS_ID, 8'h00, '0, tok_line_q, tok_col_q);
    run_idle   = 1'b0;

    // position counting, every byte but a newline counts as a column
    line_d = line_q;
    col_d  = col_q + 16'd1;
    if (c == CH_LF) begin
      col_d  = '0;
      line_d = line_q + 16'd1;
    end

    if (c != CH_CR) begin
      unique case (mode_q)
        MODE_ID: begin
          if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
            a_v = 1'b1;
            if (full) begin
              a_res  = mk_res(EV_COMPLETE, CLS_TOO_LONG, c, cnt_q, tok_line_q, tok_col_q);
              mode_d = MODE_IDLE;
              cnt_d  = '0;
              olz_d  = 1'b0;
            end else begin
              a_res = mk_res(EV_APPEND, CLS_ID, c, cnt_inc, tok_line_q, tok_col_q);
              cnt_d = cnt_inc;
            end
          end else begin
            a_v      = 1'b1;
            a_res    = mk_res(EV_COMPLETE, CLS_ID, 8'h00, cnt_q, tok_line_q, tok_col_q);
            run_idle = 1'b1;
          end
        end
        MODE_NUM: begin
          if ((olz_q && (lc == CH_LX || lc == CH_LB)) || is_lxdigit(lc) || lc == CH_LH) begin
            a_v   = 1'b1;
            olz_d = 1'b0;
            if (full) begin
              a_res  = mk_res(EV_COMPLETE, CLS_TOO_LONG, lc, cnt_q, tok_line_q, tok_col_q);
              mode_d = MODE_IDLE;
              cnt_d  = '0;
            end else begin
              a_res = mk_res(EV_APPEND, CLS_NUMBER, lc, cnt_inc, tok_line_q, tok_col_q);
              cnt_d = cnt_inc;
            end
          end else begin
            a_v      = 1'b1;
            a_res    = mk_res(EV_COMPLETE, CLS_NUMBER, 8'h00, cnt_q, tok_line_q, tok_col_q);
            run_idle = 1'b1;
          end
        end
        default: begin
          run_idle = 1'b1;
        end
      endcase

      if (run_idle) begin
        mode_d     = idl_mode;
        cnt_d      = idl_cnt;
        olz_d      = idl_olz;
        tok_line_d = line_d;
        tok_col_d  = col_d;
      end
    end
  end

  // an 'h' suffix closes the number right after its append; hex digits
  // other than 'h' keep it open, so this is the only two-result append
  logic h_close;
  assign h_close = (c != CH_CR) && (mode_q == MODE_NUM) && !full && (lc == CH_LH)
                   && !(olz_q && (lc == CH_LX || lc == CH_LB)) && !is_lxdigit(lc);

  logic [1:0] h_mode;
  always_comb begin
    h_mode = h_close ? MODE_IDLE : mode_d;
  end

  // --------------------------------------------------------------------------
  // assemble up to two results for the queue
  // --------------------------------------------------------------------------
  csl_res_t e0, e1;
  logic [1:0] n_res;
  logic       b_v;
  csl_res_t   b_res;

  always_comb begin
    b_v   = (run_idle && idl_v) || h_close;
    b_res = h_close ? mk_res(EV_COMPLETE, CLS_NUMBER, 8'h00, cnt_inc, tok_line_q, tok_col_q)
                    : idl_res;
    n_res = {1'b0, a_v} + {1'b0, b_v};
    e0    = a_v ? a_res : b_res;
    e1    = b_res;
    if (n_res == 2'd2) begin
      e1.last = 1'b1;
    end else begin
      e0.last = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // result queue
  // --------------------------------------------------------------------------
  csl_res_t             q_mem [QDepth];
  logic [QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]     q_cnt_q;
  logic                 pop;
  logic [QCntW-1:0]     push_n;

  assign s_axis_tready = (q_cnt_q <= QCntW'(QDepth - 2));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (q_cnt_q != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign push_n        = accept ? QCntW'(n_res) : '0;

  always_ff @(posedge clk_i) begin
    if (accept && n_res != 2'd0) begin
      q_mem[wr_ptr_q] <= e0;
    end
    if (accept && n_res == 2'd2) begin
      q_mem[wr_ptr_q + QPtrW'(1)] <= e1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(push_n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      q_cnt_q <= q_cnt_q + push_n - QCntW'(pop);
    end
  end

  // state registers move only with an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      cnt_q      <= '0;
      line_q     <= 16'd1;
      col_q      <= '0;
      tok_line_q <= '0;
      tok_col_q  <= '0;
      olz_q      <= 1'b0;
    end else if (accept) begin
      mode_q     <= h_mode;
      cnt_q      <= h_close ? '0 : cnt_d;
      line_q     <= line_d;
      col_q      <= col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      olz_q      <= olz_d;
    end
  end

  // --------------------------------------------------------------------------
  // output packing
  // --------------------------------------------------------------------------
  csl_res_t head;
  assign head          = q_mem[rd_ptr_q];
  assign m_axis_tdata  = {1'b0, head.start_col, head.start_line,
                          head.token_length, head.char_value};
  assign m_axis_tuser  = {head.token_class, head.event_res};
  assign m_axis_tlast  = head.last;

endmodule
`default_nettype wire

FILE: rtl/core/csl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csl_checker
// port-level checks of the c source lexer, bound to the top level
// ----------------------------------------------------------------------------
module csl_checker
  import csl_pkg::*;
(
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [47:0] m_axis_tdata,
  input wire [4:0]  m_axis_tuser,
  input wire        m_axis_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // with nothing pending the lexer takes a byte
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("not ready with empty result queue");

  // appends belong to identifiers or numbers only
  a_append_cls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[0] == EV_APPEND) |->
      (m_axis_tuser[4:1] == CLS_ID) || (m_axis_tuser[4:1] == CLS_NUMBER))
    else $error("append with a bad class");

  // commas, newline and end carry no character and no length
  a_punct_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[0] == EV_COMPLETE)
      && (m_axis_tuser[4:1] == CLS_NEWLINE || m_axis_tuser[4:1] == CLS_END
          || m_axis_tuser[4:1] == CLS_COMMA) |->
      (m_axis_tdata[14:0] == 15'd0) && m_axis_tlast)
    else $error("single-char token with nonzero payload");

endmodule

bind c_source_lexer csl_checker u_csl_checker (.*);
`default_nettype wire
